### src/lsp2xy_pkg.sv
package lsp2xy_pkg;

    localparam int RANGE_W   = 16;
    localparam int INDEX_W   = 12;
    localparam int ANGLE_W   = 17;
    localparam int OUT_ANG_W = 18;
    localparam int COORD_W   = 17;
    localparam int PTS_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 17;

    localparam int DEF_MAX_SCAN_POINTS = 4096;

    // Divider: numerator 2*|span*index| + points, denominator 2*points.
    localparam int DIV_NUM_W = 30;
    localparam int DIV_DEN_W = PTS_W + 1;

    localparam int CORDIC_STEPS = 20;
    localparam int VEC_W        = 33;
    localparam int ZW           = 32;
    localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam int ANGLE_LIMIT = 72000;
    localparam int COORD_LIMIT = 65535;
    localparam int FULL_TURN   = 36000;
    localparam int HALF_TURN   = 18000;
    localparam int QUARTER     = 9000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START  = 3'd0,
        REG_END    = 3'd1,
        REG_NEAR   = 3'd2,
        REG_FAR    = 3'd3,
        REG_POINTS = 3'd4,
        REG_CCW    = 3'd5
    } t_reg_idx;

    // Payload travelling alongside the divider.
    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               neg;
    } t_div_tag;

    // Payload travelling alongside the rotation stages.
    typedef struct packed {
        logic [RANGE_W-1:0]          range_mm;
        logic                        flip;
        logic signed [OUT_ANG_W-1:0] angle;
    } t_rot_tag;

    function automatic logic signed [ZW-1:0] atan_units(input int i);
        logic signed [ZW-1:0] v;
        v = '0;
        case (i)
            0:  v = 32'sd294912000;
            1:  v = 32'sd174096719;
            2:  v = 32'sd91987925;
            3:  v = 32'sd46694507;
            4:  v = 32'sd23437865;
            5:  v = 32'sd11730358;
            6:  v = 32'sd5866610;
            7:  v = 32'sd2933484;
            8:  v = 32'sd1466764;
            9:  v = 32'sd733385;
            10: v = 32'sd366693;
            11: v = 32'sd183346;
            12: v = 32'sd91673;
            13: v = 32'sd45837;
            14: v = 32'sd22918;
            15: v = 32'sd11459;
            16: v = 32'sd5730;
            17: v = 32'sd2865;
            18: v = 32'sd1432;
            19: v = 32'sd716;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### src/lsp2xy_div.sv
module lsp2xy_div #(
    parameter int NW = lsp2xy_pkg::DIV_NUM_W,
    parameter int DW = lsp2xy_pkg::DIV_DEN_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [NW-1:0]         i_num,
    input  logic [DW-1:0]         i_den,
    input  lsp2xy_pkg::t_div_tag  i_tag,
    output logic                  o_valid,
    output logic [NW-1:0]         o_quot,
    output lsp2xy_pkg::t_div_tag  o_tag
);
    import lsp2xy_pkg::*;

    // One quotient bit per stage, most significant first.
    logic          r_v   [NW];
    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [NW-1:0] r_q   [NW];
    t_div_tag      r_tag [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          v_in;
        logic [DW-1:0] rem_in;
        logic [NW-1:0] num_in;
        logic [NW-1:0] q_in;
        t_div_tag      tag_in;
        logic [DW:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = '0;
            assign num_in = i_num;
            assign q_in   = '0;
            assign tag_in = i_tag;
        end else begin : g_rest
            assign v_in   = r_v[k-1];
            assign rem_in = r_rem[k-1];
            assign num_in = r_num[k-1];
            assign q_in   = r_q[k-1];
            assign tag_in = r_tag[k-1];
        end

        assign trial = {rem_in, num_in[NW-1-k]};
        assign ge    = (trial >= {1'b0, i_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? DW'(trial - {1'b0, i_den}) : DW'(trial);
            r_num[k] <= num_in;
            r_q[k]   <= q_in | (NW'(ge) << (NW-1-k));
            r_tag[k] <= tag_in;
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quot  = r_q[NW-1];
    assign o_tag   = r_tag[NW-1];

endmodule

### src/lsp2xy_cordic.sv
module lsp2xy_cordic (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    input  logic signed [lsp2xy_pkg::ZW-1:0]            i_z,
    input  lsp2xy_pkg::t_rot_tag                        i_tag,
    output logic                                        o_valid,
    output logic signed [lsp2xy_pkg::VEC_W-1:0]         o_cos,
    output logic signed [lsp2xy_pkg::VEC_W-1:0]         o_sin,
    output lsp2xy_pkg::t_rot_tag                        o_tag
);
    import lsp2xy_pkg::*;

    logic                    r_v   [CORDIC_STEPS];
    logic signed [VEC_W-1:0] r_x   [CORDIC_STEPS];
    logic signed [VEC_W-1:0] r_y   [CORDIC_STEPS];
    logic signed [ZW-1:0]    r_z   [CORDIC_STEPS];
    t_rot_tag                r_tag [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic                    v_in;
        logic signed [VEC_W-1:0] x_in;
        logic signed [VEC_W-1:0] y_in;
        logic signed [ZW-1:0]    z_in;
        t_rot_tag                tag_in;
        logic signed [VEC_W-1:0] dx;
        logic signed [VEC_W-1:0] dy;

        if (i == 0) begin : g_first
            assign v_in   = i_valid;
            assign x_in   = CORDIC_GAIN;
            assign y_in   = '0;
            assign z_in   = i_z;
            assign tag_in = i_tag;
        end else begin : g_rest
            assign v_in   = r_v[i-1];
            assign x_in   = r_x[i-1];
            assign y_in   = r_y[i-1];
            assign z_in   = r_z[i-1];
            assign tag_in = r_tag[i-1];
        end

        assign dx = y_in >>> i;
        assign dy = x_in >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else begin
                r_v[i] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (z_in >= 0) begin
                r_x[i] <= x_in - dx;
                r_y[i] <= y_in + dy;
                r_z[i] <= z_in - atan_units(i);
            end else begin
                r_x[i] <= x_in + dx;
                r_y[i] <= y_in - dy;
                r_z[i] <= z_in + atan_units(i);
            end
            r_tag[i] <= tag_in;
        end
    end

    assign o_valid = r_v[CORDIC_STEPS-1];
    assign o_cos   = r_x[CORDIC_STEPS-1];
    assign o_sin   = r_y[CORDIC_STEPS-1];
    assign o_tag   = r_tag[CORDIC_STEPS-1];

endmodule

### src/laser_scan_polar_to_xy.sv
// Throughput: one request per cycle; busy is never raised. The 30-stage restoring
// divider and the 20-stage rotation pipeline hold most of the pipeline registers.
// Samples that fail the range test produce no strobe. Reset (synchronous, active
// low) empties the pipeline and loads the default scan configuration; the
// receiver cannot stall the results.
module laser_scan_polar_to_xy #(
    parameter int MAX_SCAN_POINTS = lsp2xy_pkg::DEF_MAX_SCAN_POINTS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         start,
    output logic                                         busy,
    input  logic [lsp2xy_pkg::RANGE_W-1:0]               i_range_mm,
    input  logic [lsp2xy_pkg::INDEX_W-1:0]               i_beam_index,
    input  logic                                         i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  logic [lsp2xy_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [lsp2xy_pkg::CFG_DAT_W-1:0]             i_cfg_data,
    output logic                                         o_valid,
    output logic signed [lsp2xy_pkg::COORD_W-1:0]        o_point_x_mm,
    output logic signed [lsp2xy_pkg::COORD_W-1:0]        o_point_y_mm,
    output logic signed [lsp2xy_pkg::OUT_ANG_W-1:0]      o_beam_angle_cdeg
);
    import lsp2xy_pkg::*;

    // Configuration registers
    logic signed [ANGLE_W-1:0] r_start;
    logic signed [ANGLE_W-1:0] r_end;
    logic [RANGE_W-1:0]        r_near;
    logic [RANGE_W-1:0]        r_far;
    logic [PTS_W-1:0]          r_points;
    logic                      r_ccw;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= -17'sd13500;
            r_end    <= 17'sd13500;
            r_near   <= '0;
            r_far    <= 16'hFFFF;
            r_points <= 13'd1080;
            r_ccw    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_START:  r_start  <= i_cfg_data;
                REG_END:    r_end    <= i_cfg_data;
                REG_NEAR:   r_near   <= i_cfg_data[RANGE_W-1:0];
                REG_FAR:    r_far    <= i_cfg_data[RANGE_W-1:0];
                REG_POINTS: r_points <= i_cfg_data[PTS_W-1:0];
                REG_CCW:    r_ccw    <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Effective point count: zero counts as one, and it never exceeds the maximum.
    logic [PTS_W-1:0]     pts_eff;
    logic [DIV_DEN_W-1:0] div_den;

    always_comb begin
        pts_eff = r_points;
        if (r_points == '0) begin
            pts_eff = PTS_W'(1);
        end else if (32'(r_points) > 32'(MAX_SCAN_POINTS)) begin
            pts_eff = PTS_W'(MAX_SCAN_POINTS);
        end
    end

    assign div_den = {pts_eff, 1'b0};

    // Stage 0: range test and span times index.
    logic                        keep;
    logic signed [ANGLE_W:0]     span;
    logic                        r0_v;
    logic signed [29:0]          r0_prod;
    logic [RANGE_W-1:0]          r0_range;

    assign keep = start && !busy && (i_range_mm > RANGE_W'(10))
               && (i_range_mm > r_near) && (i_range_mm < r_far);
    assign span = 18'(r_end) - 18'(r_start);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= keep;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_prod  <= 30'(span * $signed({1'b0, i_beam_index}));
        r0_range <= i_range_mm;
    end

    // Stage 1: magnitude and rounding offset for the divider.
    logic                 r1_v;
    logic [DIV_NUM_W-1:0] r1_num;
    t_div_tag             r1_tag;
    logic [29:0]          prod_mag;

    assign prod_mag = r0_prod[29] ? 30'(-r0_prod) : 30'(r0_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_num          <= DIV_NUM_W'({prod_mag, 1'b0}) + DIV_NUM_W'(pts_eff);
        r1_tag.range_mm <= r0_range;
        r1_tag.neg      <= r0_prod[29];
    end

    logic                 div_v;
    logic [DIV_NUM_W-1:0] div_q;
    t_div_tag             div_tag;

    lsp2xy_div #(
        .NW (DIV_NUM_W),
        .DW (DIV_DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_v),
        .i_num   (r1_num),
        .i_den   (div_den),
        .i_tag   (r1_tag),
        .o_valid (div_v),
        .o_quot  (div_q),
        .o_tag   (div_tag)
    );

    // Stage 2: beam angle with saturation.
    logic signed [31:0]          sq;
    logic signed [31:0]          ang_raw;
    logic signed [OUT_ANG_W-1:0] ang_sat;
    logic                        r2_v;
    logic signed [OUT_ANG_W-1:0] r2_ang;
    logic [RANGE_W-1:0]          r2_range;

    always_comb begin
        sq      = div_tag.neg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
        ang_raw = r_ccw ? (32'(r_end) - sq) : (32'(r_start) + sq);
        if (ang_raw > 32'sd72000) begin
            ang_sat = OUT_ANG_W'(ANGLE_LIMIT);
        end else if (ang_raw < -32'sd72000) begin
            ang_sat = -OUT_ANG_W'(ANGLE_LIMIT);
        end else begin
            ang_sat = OUT_ANG_W'(ang_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_ang   <= ang_sat;
        r2_range <= div_tag.range_mm;
    end

    // Stage 3: fold the angle into a quarter turn either side of zero.
    logic signed [OUT_ANG_W-1:0] a1;
    logic signed [OUT_ANG_W-1:0] a2;
    logic signed [OUT_ANG_W-1:0] a3;
    logic                        fl;
    logic                        r3_v;
    logic signed [ZW-1:0]        r3_z;
    t_rot_tag                    r3_tag;

    always_comb begin
        // Truncating remainder by a full turn.
        a1 = r2_ang;
        if (a1 >= OUT_ANG_W'(FULL_TURN)) begin
            a1 = a1 - OUT_ANG_W'(FULL_TURN);
        end else if (a1 <= -OUT_ANG_W'(FULL_TURN)) begin
            a1 = a1 + OUT_ANG_W'(FULL_TURN);
        end
        if (a1 >= OUT_ANG_W'(FULL_TURN)) begin
            a1 = a1 - OUT_ANG_W'(FULL_TURN);
        end else if (a1 <= -OUT_ANG_W'(FULL_TURN)) begin
            a1 = a1 + OUT_ANG_W'(FULL_TURN);
        end
        a2 = a1;
        if (a2 >= OUT_ANG_W'(HALF_TURN)) begin
            a2 = a2 - OUT_ANG_W'(FULL_TURN);
        end else if (a2 < -OUT_ANG_W'(HALF_TURN)) begin
            a2 = a2 + OUT_ANG_W'(FULL_TURN);
        end
        a3 = a2;
        fl = 1'b0;
        if (a2 > OUT_ANG_W'(QUARTER)) begin
            a3 = a2 - OUT_ANG_W'(HALF_TURN);
            fl = 1'b1;
        end else if (a2 < -OUT_ANG_W'(QUARTER)) begin
            a3 = a2 + OUT_ANG_W'(HALF_TURN);
            fl = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_z            <= ZW'(a3) <<< 16;
        r3_tag.range_mm <= r2_range;
        r3_tag.flip     <= fl;
        r3_tag.angle    <= r2_ang;
    end

    logic                    rot_v;
    logic signed [VEC_W-1:0] rot_c;
    logic signed [VEC_W-1:0] rot_s;
    t_rot_tag                rot_tag;

    lsp2xy_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_v),
        .i_z     (r3_z),
        .i_tag   (r3_tag),
        .o_valid (rot_v),
        .o_cos   (rot_c),
        .o_sin   (rot_s),
        .o_tag   (rot_tag)
    );

    // Stage 4: partial products of range times cosine and sine.
    logic signed [VEC_W-1:0] c_f;
    logic signed [VEC_W-1:0] s_f;
    logic signed [RANGE_W:0] range_s;
    logic                    r4_v;
    logic signed [33:0]      r4_xh;
    logic signed [33:0]      r4_yh;
    logic [31:0]             r4_xl;
    logic [31:0]             r4_yl;
    logic signed [OUT_ANG_W-1:0] r4_ang;

    assign c_f     = rot_tag.flip ? -rot_c : rot_c;
    assign s_f     = rot_tag.flip ? -rot_s : rot_s;
    assign range_s = $signed({1'b0, rot_tag.range_mm});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= rot_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_xh  <= range_s * $signed(c_f[VEC_W-1:16]);
        r4_yh  <= range_s * $signed(s_f[VEC_W-1:16]);
        r4_xl  <= rot_tag.range_mm * c_f[15:0];
        r4_yl  <= rot_tag.range_mm * s_f[15:0];
        r4_ang <= rot_tag.angle;
    end

    // Stage 5: full products.
    logic                        r5_v;
    logic signed [49:0]          r5_px;
    logic signed [49:0]          r5_py;
    logic signed [OUT_ANG_W-1:0] r5_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_px  <= (50'(r4_xh) <<< 16) + $signed(50'(r4_xl));
        r5_py  <= (50'(r4_yh) <<< 16) + $signed(50'(r4_yl));
        r5_ang <= r4_ang;
    end

    // Stage 6: round away from zero, negate and saturate.
    function automatic logic signed [COORD_W-1:0] neg_round(input logic signed [49:0] p);
        logic [49:0] mag;
        logic [19:0] qm;
        logic [15:0] m;
        mag = p[49] ? 50'(-p) : 50'(p);
        qm  = 20'((mag + 50'(1 << 29)) >> 30);
        m   = (qm > 20'(COORD_LIMIT)) ? 16'(COORD_LIMIT) : qm[15:0];
        return p[49] ? $signed({1'b0, m}) : -$signed({1'b0, m});
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_point_x_mm      <= neg_round(r5_px);
        o_point_y_mm      <= neg_round(r5_py);
        o_beam_angle_cdeg <= r5_ang;
    end

endmodule

### src/lsp2xy_checker.sv
module lsp2xy_checker (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    busy,
    input logic                                    o_valid,
    input logic signed [lsp2xy_pkg::COORD_W-1:0]   o_point_x_mm,
    input logic signed [lsp2xy_pkg::COORD_W-1:0]   o_point_y_mm,
    input logic signed [lsp2xy_pkg::OUT_ANG_W-1:0] o_beam_angle_cdeg
);
    import lsp2xy_pkg::*;

    // The pipeline never refuses a request.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // Reset empties the pipeline.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    a_angle_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_beam_angle_cdeg <= 18'sd72000 && o_beam_angle_cdeg >= -18'sd72000))
        else $error("beam angle outside saturation limits");

    a_coord_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_point_x_mm != -17'sd65536 && o_point_y_mm != -17'sd65536))
        else $error("coordinate outside saturation limits");

endmodule

bind laser_scan_polar_to_xy lsp2xy_checker u_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .busy              (busy),
    .o_valid           (o_valid),
    .o_point_x_mm      (o_point_x_mm),
    .o_point_y_mm      (o_point_y_mm),
    .o_beam_angle_cdeg (o_beam_angle_cdeg)
);

### tb/laser_scan_polar_to_xy_tb.sv
`timescale 1ns / 1ps

module laser_scan_polar_to_xy_tb;
    import lsp2xy_pkg::*;

    localparam int           PIPE_DELAY  = 58;
    localparam logic [2:0]   REG_SPARE_A = 3'd6;
    localparam logic [2:0]   REG_SPARE_B = 3'd7;
    localparam longint       ATAN_TAB [CORDIC_STEPS] = '{
        294912000, 174096719, 91987925, 46694507, 23437865,
        11730358, 5866610, 2933484, 1466764, 733385,
        366693, 183346, 91673, 45837, 22918,
        11459, 5730, 2865, 1432, 716
    };

    typedef struct {
        logic signed [COORD_W-1:0]   x;
        logic signed [COORD_W-1:0]   y;
        logic signed [OUT_ANG_W-1:0] ang;
    } t_point;

    typedef struct {
        logic [RANGE_W-1:0] range_mm;
        logic [INDEX_W-1:0] index;
        bit                 dropped;  // typed in: the range test must reject it
    } t_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [RANGE_W-1:0]          i_range_mm;
    logic [INDEX_W-1:0]          i_beam_index;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_DAT_W-1:0]        i_cfg_data;
    logic                        o_valid;
    logic signed [COORD_W-1:0]   o_point_x_mm;
    logic signed [COORD_W-1:0]   o_point_y_mm;
    logic signed [OUT_ANG_W-1:0] o_beam_angle_cdeg;

    // Shadow copy of the scan configuration.
    longint scan_start, scan_end, near_mm, far_mm, scan_points;
    bit     scan_ccw;

    t_point pending_points[$];
    int     mismatches;
    int     requests_sent;
    int     points_seen;
    int     sender_idle_pct;

    laser_scan_polar_to_xy i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_range_mm        (i_range_mm),
        .i_beam_index      (i_beam_index),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_point_x_mm      (o_point_x_mm),
        .o_point_y_mm      (o_point_y_mm),
        .o_beam_angle_cdeg (o_beam_angle_cdeg)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic void rotate(longint cdeg, output longint c, output longint s);
        longint t, x, y, z, dx, dy;
        bit     flip;
        t    = cdeg % FULL_TURN;
        flip = 0;
        x    = CORDIC_GAIN;
        y    = 0;
        if (t >= HALF_TURN) t -= FULL_TURN;
        if (t < -HALF_TURN) t += FULL_TURN;
        if (t > QUARTER) begin
            t -= HALF_TURN;
            flip = 1;
        end else if (t < -QUARTER) begin
            t += HALF_TURN;
            flip = 1;
        end
        z = t * 65536;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Returns 1 and the expected point when the sample passes the range test.
    function automatic bit project_sample(longint r, longint idx, output t_point p);
        longint pts, q, ang, c, s;
        if (!(r > 10 && r > near_mm && r < far_mm)) return 0;
        pts = scan_points;
        if (pts < 1) pts = 1;
        if (pts > DEF_MAX_SCAN_POINTS) pts = DEF_MAX_SCAN_POINTS;
        q   = round_div((scan_end - scan_start) * idx, pts);
        ang = clip(scan_ccw ? scan_end - q : scan_start + q, ANGLE_LIMIT);
        rotate(ang, c, s);
        p.x   = clip(-round_div(r * c, longint'(1) << 30), COORD_LIMIT);
        p.y   = clip(-round_div(r * s, longint'(1) << 30), COORD_LIMIT);
        p.ang = ang;
        return 1;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            points_seen++;
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point x=%0d y=%0d ang=%0d",
                             o_point_x_mm, o_point_y_mm, o_beam_angle_cdeg);
            end else begin
                t_point e;
                e = pending_points.pop_front();
                if (e.x !== o_point_x_mm || e.y !== o_point_y_mm
                        || e.ang !== o_beam_angle_cdeg) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("point mismatch: expected x=%0d y=%0d ang=%0d, got x=%0d y=%0d ang=%0d",
                                 e.x, e.y, e.ang, o_point_x_mm, o_point_y_mm,
                                 o_beam_angle_cdeg);
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DAT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_START:  scan_start  = longint'($signed(value[CFG_DAT_W-1:0]));
            REG_END:    scan_end    = longint'($signed(value[CFG_DAT_W-1:0]));
            REG_NEAR:   near_mm     = value & 16'hFFFF;
            REG_FAR:    far_mm      = value & 16'hFFFF;
            REG_POINTS: scan_points = value & 13'h1FFF;
            REG_CCW:    scan_ccw    = value[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic configure(longint st, longint en, longint nr, longint fr,
                             longint pts, bit ccw);
        write_reg(REG_START, st);
        write_reg(REG_END, en);
        write_reg(REG_NEAR, nr);
        write_reg(REG_FAR, fr);
        write_reg(REG_POINTS, pts);
        write_reg(REG_CCW, ccw);
    endtask

    // Lets the pipeline run dry so that a rejected sample still in flight is gone too.
    task automatic drain_pipeline();
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (PIPE_DELAY + 10) @(posedge i_clk);
    endtask

    task automatic send_request(logic [RANGE_W-1:0] r, logic [INDEX_W-1:0] idx,
                                output bit kept);
        t_point p;
        if (sender_idle_pct > 0) begin
            while ($urandom_range(99) < sender_idle_pct) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start        <= 1'b1;
        i_range_mm   <= r;
        i_beam_index <= idx;
        do @(posedge i_clk); while (busy);
        requests_sent++;
        kept = project_sample(r, idx, p);
        if (kept) pending_points = {pending_points, p};
    endtask

    task automatic random_burst(int count);
        bit  kept;
        logic [RANGE_W-1:0] r;
        logic [INDEX_W-1:0] idx;
        longint pts;
        pts = (scan_points < 1) ? 1 :
              (scan_points > DEF_MAX_SCAN_POINTS) ? DEF_MAX_SCAN_POINTS : scan_points;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0:       r = $urandom_range(15);
                1:       r = 16'(near_mm + $urandom_range(2)) - 16'd1;
                2:       r = 16'(far_mm - $urandom_range(2)) + 16'd1;
                3:       r = $urandom;
                default: r = 16'(near_mm + 1 + $urandom_range(
                               (far_mm > near_mm + 1) ? far_mm - near_mm - 2 : 0));
            endcase
            if ($urandom_range(4) == 0) idx = $urandom;
            else                        idx = $urandom_range(pts - 1 < 4095 ? pts - 1 : 4095);
            send_request(r, idx, kept);
            if (n == count / 2) begin
                start <= 1'b0;
                do @(posedge i_clk); while (pending_points.size() != 0);
            end
        end
        start <= 1'b0;
    endtask

    t_row directed[] = '{
        '{16'd0,     12'd0,    1'b1},
        '{16'd10,    12'd5,    1'b1},
        '{16'd65535, 12'd100,  1'b1},
        '{16'd11,    12'd0,    1'b0},
        '{16'd1000,  12'd0,    1'b0},
        '{16'd1000,  12'd540,  1'b0},
        '{16'd1000,  12'd1080, 1'b0},
        '{16'd65534, 12'd270,  1'b0},
        '{16'd65534, 12'd810,  1'b0},
        '{16'd40000, 12'd4095, 1'b0},
        '{16'd5000,  12'd2048, 1'b0},
        '{16'd12345, 12'd1,    1'b0},
        '{16'd32768, 12'd360,  1'b0},
        '{16'd21845, 12'd2730, 1'b0}
    };

    initial begin
        bit kept;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_range_mm      = '0;
        i_beam_index    = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = REG_START;
        i_cfg_data      = '0;
        mismatches      = 0;
        requests_sent   = 0;
        points_seen     = 0;
        sender_idle_pct = 0;
        scan_start  = -13500;
        scan_end    = 13500;
        near_mm     = 0;
        far_mm      = 65535;
        scan_points = 1080;
        scan_ccw    = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Defaults after reset first, then the same rows with edge cases of the settings.
        foreach (directed[k]) begin
            send_request(directed[k].range_mm, directed[k].index, kept);
            if (directed[k].dropped && kept) begin
                mismatches++;
                $display("row %0d should have been rejected by the range test", k);
            end
        end
        start <= 1'b0;
        drain_pipeline();
        configure(36000, -36000, 0, 65535, 0, 1);
        foreach (directed[k]) send_request(directed[k].range_mm, directed[k].index, kept);
        start <= 1'b0;
        drain_pipeline();
        configure(-36000, 36000, 65534, 65535, 8191, 0);
        write_reg(REG_SPARE_A, 17'h1FFFF);
        write_reg(REG_SPARE_B, 0);
        send_request(16'd65534, 12'd7, kept);
        send_request(16'd65535, 12'd7, kept);
        start <= 1'b0;
        drain_pipeline();

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 80 : 0;
            configure(-13500, 13500, 0, 65535, 1080, 0);
            random_burst(150);
            drain_pipeline();
            configure($urandom_range(72000) - 36000, $urandom_range(72000) - 36000,
                      $urandom_range(3000), 60000 + $urandom_range(5535),
                      1 + $urandom_range(4095), $urandom_range(1));
            random_burst(150);
            drain_pipeline();
            configure(-36000, 36000, 65535, 0, 4096, 1);
            random_burst(10);
            drain_pipeline();
            configure(36000, -36000, 0, 65535, 1 + $urandom_range(7), $urandom_range(1));
            random_burst(120);
            drain_pipeline();
        end

        $display("Sent %0d samples over directed rows and twelve random settings,", requests_sent);
        $display("including range limits, saturated angles and both scan directions; %0d points checked.",
                 points_seen);
        if (mismatches == 0 && pending_points.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
src/lsp2xy_pkg.sv
src/lsp2xy_div.sv
src/lsp2xy_cordic.sv
src/laser_scan_polar_to_xy.sv
src/lsp2xy_checker.sv
tb/laser_scan_polar_to_xy_tb.sv
